// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst
`define PPA_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst
`define PPA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ppa_pkg.sv =====
// Types and constants of the page pool allocator
package ppa_pkg;

  localparam int ADDR_W      = 32;
  localparam int SHIFT_W     = 5;
  localparam int CNT_FIELD_W = 7;
  localparam int IDX_FIELD_W = 6;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

  // request types
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT = 1'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REFUSE,
    S_SCAN,
    S_RELEASE
  } state_t;

  // shared address unit operation
  typedef enum logic {
    OP_ADDR,
    OP_OFFSET
  } unit_op_t;

  // update command to the occupancy map
  typedef struct packed {
    logic set;
    logic clr;
  } map_cmd_t;

endpackage

// ===== rtl/core/ppa_if.sv =====
// Handshake interfaces: request, result and configuration channels

interface ppa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [ppa_pkg::CNT_FIELD_W-1:0] page_count;
  logic [ppa_pkg::ADDR_W-1:0] release_address;

  modport source (output valid, output req_type, output page_count,
                  output release_address, input ready);
  modport sink   (input valid, input req_type, input page_count,
                  input release_address, output ready);
endinterface

interface ppa_res_if;
  logic                            valid;
  logic                            ready;
  logic [ppa_pkg::ADDR_W-1:0]      page_address;
  logic [ppa_pkg::IDX_FIELD_W-1:0] page_index;
  logic [ppa_pkg::STATUS_W-1:0]    status;
  logic [ppa_pkg::CNT_FIELD_W-1:0] free_count;
  logic                            last;

  modport source (output valid, output page_address, output page_index,
                  output status, output free_count, output last, input ready);
  modport sink   (input valid, input page_address, input page_index,
                  input status, input free_count, input last, output ready);
endinterface

interface ppa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ppa_pkg::CFG_IDX_W-1:0] index;
  logic [ppa_pkg::ADDR_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ppa_addr_unit.sv =====
// Shared address unit: page address for grants, offset decode for releases
module ppa_addr_unit #(
  parameter int PAGES = 64
) (
  input  ppa_pkg::unit_op_t            op,
  input  logic [ppa_pkg::ADDR_W-1:0]   base,
  input  logic [ppa_pkg::ADDR_W-1:0]   raddr,
  input  logic [ppa_pkg::SHIFT_W-1:0]  shift,
  input  logic [$clog2(PAGES)-1:0]     idx,
  output logic [ppa_pkg::ADDR_W-1:0]   sum,
  output logic [$clog2(PAGES)-1:0]     rel_idx,
  output logic                         rel_bad
);

  localparam int IDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;

  logic [ppa_pkg::ADDR_W-1:0] opa;
  logic [ppa_pkg::ADDR_W-1:0] opb;
  logic                       cin;
  logic [ppa_pkg::ADDR_W-1:0] pg_off;
  logic [ppa_pkg::ADDR_W-1:0] low_mask;

  // one adder: base + (idx << shift), or raddr - base
  always_comb begin
    if (op == ppa_pkg::OP_OFFSET) begin
      opa = raddr;
      opb = ~base;
      cin = 1'b1;
    end else begin
      opa = base;
      opb = ppa_pkg::ADDR_W'(idx) << shift;
      cin = 1'b0;
    end
    sum = opa + opb + ppa_pkg::ADDR_W'(cin);
  end

  // release decode from the offset
  always_comb begin
    pg_off   = sum >> shift;
    low_mask = (ppa_pkg::ADDR_W'(1) << shift) - ppa_pkg::ADDR_W'(1);
    rel_bad  = ((sum & low_mask) != '0) || (pg_off >= ppa_pkg::ADDR_W'(PAGES));
    rel_idx  = pg_off[IDX_W-1:0];
  end

endmodule

// ===== rtl/core/ppa_page_map.sv =====
// Occupancy bitmap and free page counter
module ppa_page_map #(
  parameter int PAGES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [$clog2(PAGES)-1:0]     idx,
  input  ppa_pkg::map_cmd_t            cmd,
  output logic                         busy,
  output logic [$clog2(PAGES+1)-1:0]   free_pages
);

  localparam int CNT_W = $clog2(PAGES + 1);

  logic [PAGES-1:0] occ;

  assign busy = occ[idx];

  // mark or free one page and keep the count in step
  always_ff @(posedge clk) begin
    if (rst) begin
      occ        <= '0;
      free_pages <= CNT_W'(PAGES);
    end else if (cmd.set) begin
      occ[idx]   <= 1'b1;
      free_pages <= free_pages - CNT_W'(1);
    end else if (cmd.clr) begin
      occ[idx]   <= 1'b0;
      free_pages <= free_pages + CNT_W'(1);
    end
  end

endmodule

// ===== rtl/core/page_pool_allocator_unit.sv =====
// Page pool allocator top level: sequencer, configuration and result register
//
// Channels: req (sink) carries allocate or release requests, res (source)
// carries result items, cfg (sink) writes pool_base (index 0) and page_shift
// (index 1); cfg is always ready, and the user must write it only while the
// block is idle; the block itself does not enforce this. One request is
// worked at a time; req.ready is high only when idle. Allocate of N pages:
// the sequencer scans the occupancy map one page per cycle from page 0
// (holding at a free page while res stalls), and every free page it meets
// becomes one result item, the final one with last set. A refused allocate
// or any release gives its one result item from the S_REFUSE or S_RELEASE
// state once the output register can take it. The scan runs one bit per
// cycle through the map read port and the shared address adder.
// Results sit in an output register; while res.ready is low the scan holds
// at the current free page and resumes when the item is taken.
// Reset (synchronous, rst high) frees all pages, sets the free count to
// PAGES, pool_base to 0 and page_shift to 12, and drops res.valid.
module page_pool_allocator_unit #(
  parameter int PAGES = 64
) (
  input  logic           clk,
  input  logic           rst,
  ppa_req_if.sink        req,
  ppa_res_if.source      res,
  ppa_cfg_if.sink        cfg
);

  localparam int IDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CNT_W = $clog2(PAGES + 1);

  ppa_pkg::state_t state;
  ppa_pkg::state_t state_next;

  logic [ppa_pkg::ADDR_W-1:0]  pool_base;
  logic [ppa_pkg::SHIFT_W-1:0] page_shift;

  logic [IDX_W-1:0] scan;
  logic [IDX_W-1:0] scan_next;
  logic [CNT_W-1:0] left;
  logic [CNT_W-1:0] left_next;
  logic [ppa_pkg::ADDR_W-1:0] raddr;

  // output register
  logic                            out_valid;
  logic [ppa_pkg::ADDR_W-1:0]      out_addr;
  logic [ppa_pkg::IDX_FIELD_W-1:0] out_idx;
  logic [ppa_pkg::STATUS_W-1:0]    out_status;
  logic [ppa_pkg::CNT_FIELD_W-1:0] out_free;
  logic                            out_last;

  // values for the next result
  logic                            emit;
  logic [ppa_pkg::ADDR_W-1:0]      e_addr;
  logic [IDX_W-1:0]                e_idx;
  logic [ppa_pkg::STATUS_W-1:0]    e_status;
  logic [CNT_W-1:0]                e_free;
  logic                            e_last;

  logic                         can_emit;
  logic                         accept;
  logic                         refuse;
  logic [ppa_pkg::CNT_FIELD_W-1:0] free_ext;

  ppa_pkg::map_cmd_t  map_cmd;
  ppa_pkg::unit_op_t  unit_op;
  logic [IDX_W-1:0]   map_idx;
  logic               map_busy;
  logic [CNT_W-1:0]   free_pages;

  logic [ppa_pkg::ADDR_W-1:0] unit_sum;
  logic [IDX_W-1:0]           rel_idx;
  logic                       rel_bad;

  ppa_page_map #(.PAGES(PAGES)) u_map (
    .clk        (clk),
    .rst        (rst),
    .idx        (map_idx),
    .cmd        (map_cmd),
    .busy       (map_busy),
    .free_pages (free_pages)
  );

  ppa_addr_unit #(.PAGES(PAGES)) u_addr (
    .op      (unit_op),
    .base    (pool_base),
    .raddr   (raddr),
    .shift   (page_shift),
    .idx     (scan),
    .sum     (unit_sum),
    .rel_idx (rel_idx),
    .rel_bad (rel_bad)
  );

  assign req.ready = (state == ppa_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign can_emit  = !out_valid || res.ready;
  assign free_ext  = (ppa_pkg::CNT_FIELD_W)'(free_pages);
  assign refuse    = (req.page_count == '0) || (req.page_count > free_ext);

  assign unit_op = (state == ppa_pkg::S_RELEASE) ? ppa_pkg::OP_OFFSET : ppa_pkg::OP_ADDR;
  assign map_idx = (state == ppa_pkg::S_RELEASE) ? rel_idx : scan;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      page_shift <= ppa_pkg::SHIFT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        ppa_pkg::REG_POOL_BASE:  pool_base  <= cfg.data;
        ppa_pkg::REG_PAGE_SHIFT: page_shift <= cfg.data[ppa_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // state and sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppa_pkg::S_IDLE;
      scan  <= '0;
      left  <= '0;
    end else begin
      state <= state_next;
      scan  <= scan_next;
      left  <= left_next;
    end
  end

  // release address latch
  always_ff @(posedge clk) begin
    if (accept) begin
      raddr <= req.release_address;
    end
  end

  // next state, map command and result values
  always_comb begin
    state_next = state;
    scan_next  = scan;
    left_next  = left;
    map_cmd    = '0;
    emit       = 1'b0;
    e_addr     = '0;
    e_idx      = '0;
    e_status   = ppa_pkg::ST_OK;
    e_free     = free_pages;
    e_last     = 1'b1;
    case (state)
      ppa_pkg::S_IDLE: begin
        if (accept) begin
          scan_next = '0;
          if (req.req_type == ppa_pkg::REQ_RELEASE) begin
            state_next = ppa_pkg::S_RELEASE;
          end else if (refuse) begin
            state_next = ppa_pkg::S_REFUSE;
          end else begin
            state_next = ppa_pkg::S_SCAN;
            left_next  = req.page_count[CNT_W-1:0];
          end
        end
      end
      ppa_pkg::S_REFUSE: begin
        e_status = ppa_pkg::ST_NO_SPACE;
        if (can_emit) begin
          emit       = 1'b1;
          state_next = ppa_pkg::S_IDLE;
        end
      end
      ppa_pkg::S_SCAN: begin
        e_addr = unit_sum;
        e_idx  = scan;
        e_free = free_pages - CNT_W'(1);
        e_last = (left == CNT_W'(1));
        if (map_busy) begin
          scan_next = scan + IDX_W'(1);
        end else if (can_emit) begin
          emit        = 1'b1;
          map_cmd.set = 1'b1;
          left_next   = left - CNT_W'(1);
          scan_next   = scan + IDX_W'(1);
          if (e_last) begin
            state_next = ppa_pkg::S_IDLE;
          end
        end
      end
      ppa_pkg::S_RELEASE: begin
        e_addr = raddr;
        if (rel_bad) begin
          e_status = ppa_pkg::ST_BAD_ADDR;
        end else if (!map_busy) begin
          e_status = ppa_pkg::ST_ALREADY_FREE;
          e_idx    = rel_idx;
        end else begin
          e_idx  = rel_idx;
          e_free = free_pages + CNT_W'(1);
        end
        if (can_emit) begin
          emit        = 1'b1;
          map_cmd.clr = !rel_bad && map_busy;
          state_next  = ppa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ppa_pkg::S_IDLE;
      end
    endcase
  end

  // output register: load a new item or drop the taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr   <= e_addr;
      out_idx    <= (ppa_pkg::IDX_FIELD_W)'(e_idx);
      out_status <= e_status;
      out_free   <= (ppa_pkg::CNT_FIELD_W)'(e_free);
      out_last   <= e_last;
    end
  end

  assign res.valid        = out_valid;
  assign res.page_address = out_addr;
  assign res.page_index   = out_idx;
  assign res.status       = out_status;
  assign res.free_count   = out_free;
  assign res.last         = out_last;

endmodule

// ===== rtl/core/ppa_checker.sv =====
// Port-level checks for the page pool allocator, bound to the top level
`include "assert_macros.svh"

module ppa_checker #(
  parameter int PAGES = 64
) (
  input logic       clk,
  input logic       rst,
  ppa_req_if.sink   req,
  ppa_res_if.source res
);

  // no new request is taken while a request still has results to give
  `PPA_ASSERT_SAME(a_busy_mid_request, res.valid && !res.last, !req.ready, "request taken mid grant")

  // a refused allocate is a single item at page zero
  `PPA_ASSERT_SAME(a_refuse_single, res.valid && (res.status == ppa_pkg::ST_NO_SPACE), res.last && (res.page_index == '0) && (res.page_address == '0), "bad refused result")

  // the free count never exceeds the pool
  `PPA_ASSERT_SAME(a_free_bound, res.valid, res.free_count <= 7'(PAGES), "free count above pool size")

  // an accepted request makes the block busy
  `PPA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")

endmodule

bind page_pool_allocator_unit ppa_checker #(.PAGES(PAGES)) u_ppa_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .res (res)
);

// ===== sim/tb.sv =====
// Testbench for the page pool allocator: directed and random requests checked against a bitmap model
`timescale 1ns / 1ps

localparam int POOL_PAGES = 64;

typedef struct packed {
  logic                            req_type;
  logic [ppa_pkg::CNT_FIELD_W-1:0] page_count;
  logic [ppa_pkg::ADDR_W-1:0]      release_address;
} page_request_t;

typedef struct packed {
  logic [ppa_pkg::ADDR_W-1:0]      page_address;
  logic [ppa_pkg::IDX_FIELD_W-1:0] page_index;
  logic [ppa_pkg::STATUS_W-1:0]    status;
  logic [ppa_pkg::CNT_FIELD_W-1:0] free_count;
  logic                            last;
} page_result_t;

// Occupancy bitmap model plus the queue of results still owed by the block
class page_pool_scoreboard;
  logic [POOL_PAGES-1:0]       taken;
  int unsigned                 free_pages;
  logic [ppa_pkg::ADDR_W-1:0]  base;
  logic [ppa_pkg::SHIFT_W-1:0] shift;
  page_result_t                results_due[$];
  int                          errors;

  function new();
    taken      = '0;
    free_pages = POOL_PAGES;
    base       = '0;
    shift      = ppa_pkg::SHIFT_RESET;
    errors     = 0;
  endfunction

  function void write_register(logic [ppa_pkg::CFG_IDX_W-1:0] idx,
                               logic [ppa_pkg::ADDR_W-1:0] data);
    if (idx == ppa_pkg::REG_POOL_BASE) begin
      base = data;
    end else if (idx == ppa_pkg::REG_PAGE_SHIFT) begin
      shift = data[ppa_pkg::SHIFT_W-1:0];
    end
  endfunction

  // address wraps modulo 2^32
  function logic [ppa_pkg::ADDR_W-1:0] page_addr(int unsigned i);
    return base + (ppa_pkg::ADDR_W'(i) << shift);
  endfunction

  // free count is taken as it stands when the result is queued
  function void queue_result(logic [ppa_pkg::ADDR_W-1:0] addr, int unsigned idx,
                             logic [ppa_pkg::STATUS_W-1:0] st, logic last);
    page_result_t r;
    r.page_address = addr;
    r.page_index   = ppa_pkg::IDX_FIELD_W'(idx);
    r.status       = st;
    r.free_count   = ppa_pkg::CNT_FIELD_W'(free_pages);
    r.last         = last;
    results_due    = {results_due, r};
  endfunction

  // Work out every result caused by one accepted request
  function void note_request(page_request_t q);
    int unsigned                left;
    logic [ppa_pkg::ADDR_W-1:0] offset;
    logic [ppa_pkg::ADDR_W-1:0] low_mask;
    int unsigned                idx;
    if (q.req_type == ppa_pkg::REQ_ALLOC) begin
      if (q.page_count == 0 || q.page_count > free_pages) begin
        queue_result('0, 0, ppa_pkg::ST_NO_SPACE, 1'b1);
      end else begin
        // first fit, ascending index
        left = 32'(q.page_count);
        for (int i = 0; i < POOL_PAGES && left > 0; i++) begin
          if (!taken[i]) begin
            taken[i] = 1'b1;
            free_pages--;
            left--;
            queue_result(page_addr(i), i, ppa_pkg::ST_OK, left == 0);
          end
        end
      end
    end else begin
      offset   = q.release_address - base;
      low_mask = ppa_pkg::ADDR_W'((64'd1 << shift) - 64'd1);
      if ((offset & low_mask) != 0 || (offset >> shift) >= POOL_PAGES) begin
        queue_result(q.release_address, 0, ppa_pkg::ST_BAD_ADDR, 1'b1);
      end else begin
        idx = offset >> shift;
        if (!taken[idx]) begin
          queue_result(q.release_address, idx, ppa_pkg::ST_ALREADY_FREE, 1'b1);
        end else begin
          taken[idx] = 1'b0;
          free_pages++;
          queue_result(q.release_address, idx, ppa_pkg::ST_OK, 1'b1);
        end
      end
    end
  endfunction

  function void check_field(string name, logic [ppa_pkg::ADDR_W-1:0] want,
                            logic [ppa_pkg::ADDR_W-1:0] seen);
    if (want !== seen) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
    end
  endfunction

  // Compare one result item with the oldest one owed
  function void check_result(page_result_t got);
    page_result_t want;
    if (results_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got addr %0h idx %0d status %0d",
               $time, got.page_address, got.page_index, got.status);
      return;
    end
    want = results_due.pop_front();
    check_field("page_address", want.page_address, got.page_address);
    check_field("page_index", ppa_pkg::ADDR_W'(want.page_index),
                ppa_pkg::ADDR_W'(got.page_index));
    check_field("status", ppa_pkg::ADDR_W'(want.status), ppa_pkg::ADDR_W'(got.status));
    check_field("free_count", ppa_pkg::ADDR_W'(want.free_count),
                ppa_pkg::ADDR_W'(got.free_count));
    check_field("last", ppa_pkg::ADDR_W'(want.last), ppa_pkg::ADDR_W'(got.last));
  endfunction
endclass

module tb;

  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_OFF     = 200;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst;

  ppa_req_if req_ch ();
  ppa_res_if res_ch ();
  ppa_cfg_if cfg_ch ();

  page_pool_allocator_unit #(.PAGES(POOL_PAGES)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  page_pool_scoreboard sb = new();

  bit calm        = 1'b0;
  bit sender_gaps = 1'b0;
  bit squeeze     = 1'b0;
  int idle_cycles = 0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result check and watchdog on accepted items
  always @(posedge clk) begin : monitor
    page_result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.page_address = res_ch.page_address;
      got.page_index   = res_ch.page_index;
      got.status       = res_ch.status;
      got.free_count   = res_ch.free_count;
      got.last         = res_ch.last;
      sb.check_result(got);
    end
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Result receiver: stall bursts in random epochs, one long hold-off on request
  initial begin : receiver
    int epoch;
    bit stalls_on;
    epoch     = 0;
    stalls_on = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze) begin
        squeeze = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else if (!calm && stalls_on && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      if (epoch == 0) begin
        epoch     = $urandom_range(40, 300);
        stalls_on = $urandom_range(0, 2) != 0;
      end else begin
        epoch--;
      end
    end
  end

  // Offer one request, optionally after a gap, and hold it until taken
  task automatic send_request(logic kind, logic [ppa_pkg::CNT_FIELD_W-1:0] count,
                              logic [ppa_pkg::ADDR_W-1:0] addr);
    page_request_t item;
    item.req_type        = kind;
    item.page_count      = count;
    item.release_address = addr;
    if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= kind;
    req_ch.page_count      <= count;
    req_ch.release_address <= addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(item);
  endtask

  // Stop offering, drain every owed result, then let the block go quiet
  task automatic wait_idle(int cycles);
    req_ch.valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  // Write both registers back to back, valid held across the pair
  task automatic apply_setting(logic [ppa_pkg::ADDR_W-1:0] base,
                               logic [ppa_pkg::SHIFT_W-1:0] shift);
    logic [ppa_pkg::CFG_IDX_W-1:0] idx;
    logic [ppa_pkg::ADDR_W-1:0]    data;
    for (int r = 0; r < 2; r++) begin
      idx  = (r == 0) ? ppa_pkg::REG_POOL_BASE : ppa_pkg::REG_PAGE_SHIFT;
      data = (r == 0) ? base : ppa_pkg::ADDR_W'(shift);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= data;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      sb.write_register(idx, data);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed alloc/release traffic with random unused fields,
  // plus refusals, double frees and bad addresses
  task automatic run_random(int n, int calm_from);
    int                              pick;
    logic                            kind;
    logic [ppa_pkg::CNT_FIELD_W-1:0] count;
    logic [ppa_pkg::ADDR_W-1:0]      addr;
    int                              used[$];
    int                              vacant[$];
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) sender_gaps = $urandom_range(0, 2) != 0;
      if (k == calm_from) calm = 1'b1;
      used   = {};
      vacant = {};
      for (int i = 0; i < POOL_PAGES; i++) begin
        if (sb.taken[i]) used = {used, i};
        else vacant = {vacant, i};
      end
      pick  = $urandom_range(0, 99);
      // steer away from allocating into a nearly full pool
      if (pick < 45 && sb.free_pages < 16 && $urandom_range(0, 1) == 0) pick += 45;
      count = ppa_pkg::CNT_FIELD_W'($urandom_range(0, 127));
      addr  = $urandom();
      if (pick < 45) begin
        kind = ppa_pkg::REQ_ALLOC;
        if (pick < 38) begin
          count = ppa_pkg::CNT_FIELD_W'($urandom_range(1, 6));
        end else if (pick < 41) begin
          count = ppa_pkg::CNT_FIELD_W'($urandom_range(7, POOL_PAGES));
        end else if (pick < 43 || sb.free_pages >= 127) begin
          count = 0;
        end else begin
          count = ppa_pkg::CNT_FIELD_W'($urandom_range(sb.free_pages + 1, 127));
        end
      end else begin
        kind = ppa_pkg::REQ_RELEASE;
        if (pick < 82 && used.size() > 0) begin
          addr = sb.page_addr(used[$urandom_range(0, used.size() - 1)]);
        end else if (pick < 88 && vacant.size() > 0) begin
          addr = sb.page_addr(vacant[$urandom_range(0, vacant.size() - 1)]);
        end else if (pick < 93) begin
          addr = sb.page_addr($urandom_range(0, POOL_PAGES - 1)) +
                 $urandom_range(1, (1 << sb.shift) - 1);
        end else if (pick < 97) begin
          addr = sb.page_addr(POOL_PAGES + $urandom_range(0, 1000));
        end
      end
      send_request(kind, count, addr);
    end
  endtask

  // Main sequence
  initial begin
    rst                    <= 1'b1;
    req_ch.valid           <= 1'b0;
    req_ch.req_type        <= ppa_pkg::REQ_ALLOC;
    req_ch.page_count      <= '0;
    req_ch.release_address <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= ppa_pkg::REG_POOL_BASE;
    cfg_ch.data            <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings (base 0, 4 KiB pages)
    send_request(ppa_pkg::REQ_ALLOC, 7'd0, 32'hFFFF_FFFF);     // zero count
    send_request(ppa_pkg::REQ_ALLOC, 7'd127, 32'h0);           // far above pool size
    send_request(ppa_pkg::REQ_ALLOC, 7'd65, 32'h0);            // one above pool size
    send_request(ppa_pkg::REQ_ALLOC, 7'd64, 32'h0);            // whole pool
    send_request(ppa_pkg::REQ_ALLOC, 7'd1, 32'h0);             // pool empty
    send_request(ppa_pkg::REQ_RELEASE, 7'd127, 32'h0003_F000); // top page
    send_request(ppa_pkg::REQ_RELEASE, 7'd0, 32'h0003_F000);   // double free
    send_request(ppa_pkg::REQ_RELEASE, 7'd0, 32'h0004_0000);   // just past the pool
    send_request(ppa_pkg::REQ_RELEASE, 7'd0, 32'h0000_0800);   // misaligned
    send_request(ppa_pkg::REQ_RELEASE, 7'd0, 32'hFFFF_FFFF);   // all ones
    send_request(ppa_pkg::REQ_RELEASE, 7'd64, 32'h0000_0000);  // page 0
    send_request(ppa_pkg::REQ_ALLOC, 7'd2, 32'hFFFF_FFFF);     // grants lowest and highest
    send_request(ppa_pkg::REQ_RELEASE, 7'd0, 32'h0000_5000);
    send_request(ppa_pkg::REQ_RELEASE, 7'd0, 32'h0000_A000);
    send_request(ppa_pkg::REQ_ALLOC, 7'd3, 32'h0);             // one short
    send_request(ppa_pkg::REQ_ALLOC, 7'd2, 32'h0);             // exact fit
    for (int i = 1; i <= 8; i++) begin
      send_request(ppa_pkg::REQ_RELEASE, 7'd0, sb.page_addr(i));
    end

    // random phases over several settings, extremes included
    wait_idle(4);
    apply_setting(32'hFFFF_FFFF, 5'd20);
    squeeze = 1'b1;
    run_random(64, 64);

    wait_idle(4);
    apply_setting(32'h0000_0000, 5'd15);
    run_random(64, 64);

    wait_idle(4);
    apply_setting($urandom(), 5'd12);
    run_random(64, 64);

    wait_idle(4);
    apply_setting($urandom(), 5'($urandom_range(12, 20)));
    run_random(64, 30);

    wait_idle(DRAIN_CYCLES);
    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0t: %0d mismatches, %0d results outstanding", $time, sb.errors,
               sb.results_due.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ppa_pkg.sv
rtl/core/ppa_if.sv
rtl/core/ppa_addr_unit.sv
rtl/core/ppa_page_map.sv
rtl/core/page_pool_allocator_unit.sv
rtl/core/ppa_checker.sv
sim/tb.sv
